FILE: hw/rtl/mbsdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsdm_pkg
// Types and constants shared by the Modbus slave data store modules.
// ----------------------------------------------------------------------------
package mbsdm_pkg;

  // Function codes
  localparam logic [7:0] FC_RD_COILS    = 8'd1;
  localparam logic [7:0] FC_RD_DISCRETE = 8'd2;
  localparam logic [7:0] FC_RD_HOLDING  = 8'd3;
  localparam logic [7:0] FC_RD_INREG    = 8'd4;
  localparam logic [7:0] FC_WR_COIL     = 8'd5;
  localparam logic [7:0] FC_WR_REG      = 8'd6;
  localparam logic [7:0] FC_WR_COILS    = 8'd15;
  localparam logic [7:0] FC_WR_REGS     = 8'd16;

  // Exception status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_FUNC = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;

  // Most bits moved by one bit access, and bits in one row of a bit store
  localparam logic [4:0] MAX_BITS = 5'd16;
  localparam int         ROW_BITS = 16;

  // Command queue between the front and back parts
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  typedef enum logic [3:0] {
    CFG_COIL_FIRST     = 4'd0,
    CFG_COIL_LAST      = 4'd1,
    CFG_DISCRETE_FIRST = 4'd2,
    CFG_DISCRETE_LAST  = 4'd3,
    CFG_HOLDING_FIRST  = 4'd4,
    CFG_HOLDING_LAST   = 4'd5,
    CFG_INREG_FIRST    = 4'd6,
    CFG_INREG_LAST     = 4'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SP_COIL  = 2'd0,
    SP_DISC  = 2'd1,
    SP_HOLD  = 2'd2,
    SP_INREG = 2'd3
  } space_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC,
    B_WRHI
  } bk_state_t;

  typedef struct packed {
    logic [7:0]  mode;
    logic        local_side;
    logic [15:0] start_address;
    logic [4:0]  element_count;
    logic        reg_width;
    logic [15:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] read_data;
  } out_item_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    logic [1:0]  status;
    logic        wr;
    space_t      space;
    logic [15:0] off;
    logic [15:0] span;
    logic [4:0]  cnt;
    logic        whole;
    logic [15:0] wd;
  } cmd_t;

  // Queue control between the top level and the command queue
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_sts_t;

endpackage

FILE: hw/rtl/mbsdm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsdm_front
// Holds the address window registers and classifies each request: function
// code check, space check for bus requests, space selection by priority.
// ----------------------------------------------------------------------------
module mbsdm_front
  import mbsdm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        valid,
  output logic        ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  in_item_t    in_item,
  output cmd_t        cmd
);

  logic [15:0] coil_first_r, coil_last_r;
  logic [15:0] disc_first_r, disc_last_r;
  logic [15:0] hold_first_r, hold_last_r;
  logic [15:0] inreg_first_r, inreg_last_r;

  function automatic logic in_win(input logic [15:0] a, input logic [15:0] lo,
                                  input logic [15:0] hi);
    in_win = (a >= lo) && (a <= hi);
  endfunction

  assign ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coil_first_r  <= 16'd0;
      coil_last_r   <= 16'd63;
      disc_first_r  <= 16'd1000;
      disc_last_r   <= 16'd1063;
      hold_first_r  <= 16'd2000;
      hold_last_r   <= 16'd2063;
      inreg_first_r <= 16'd3000;
      inreg_last_r  <= 16'd3063;
    end else if (valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_COIL_FIRST:     coil_first_r  <= cfg_data;
        CFG_COIL_LAST:      coil_last_r   <= cfg_data;
        CFG_DISCRETE_FIRST: disc_first_r  <= cfg_data;
        CFG_DISCRETE_LAST:  disc_last_r   <= cfg_data;
        CFG_HOLDING_FIRST:  hold_first_r  <= cfg_data;
        CFG_HOLDING_LAST:   hold_last_r   <= cfg_data;
        CFG_INREG_FIRST:    inreg_first_r <= cfg_data;
        CFG_INREG_LAST:     inreg_last_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic        coil_hit, disc_hit, hold_hit, inreg_hit;
  logic        bad_func, wr, need_ok;
  logic [15:0] first, last;

  always_comb begin
    coil_hit  = in_win(in_item.start_address, coil_first_r, coil_last_r);
    disc_hit  = in_win(in_item.start_address, disc_first_r, disc_last_r);
    hold_hit  = in_win(in_item.start_address, hold_first_r, hold_last_r);
    inreg_hit = in_win(in_item.start_address, inreg_first_r, inreg_last_r);

    bad_func = 1'b0;
    wr       = 1'b0;
    need_ok  = hold_hit;
    case (in_item.mode)
      FC_RD_COILS:    need_ok = coil_hit;
      FC_RD_DISCRETE: need_ok = disc_hit;
      FC_RD_HOLDING:  need_ok = hold_hit;
      FC_RD_INREG:    need_ok = inreg_hit;
      FC_WR_COIL, FC_WR_COILS: begin
        wr      = 1'b1;
        need_ok = coil_hit;
      end
      FC_WR_REG, FC_WR_REGS: begin
        wr      = 1'b1;
        need_ok = hold_hit;
      end
      default: bad_func = 1'b1;
    endcase

    // Overlapping windows resolve in the order coils, discrete, holding, input.
    if (coil_hit) begin
      cmd.space = SP_COIL;
      first     = coil_first_r;
      last      = coil_last_r;
    end else if (disc_hit) begin
      cmd.space = SP_DISC;
      first     = disc_first_r;
      last      = disc_last_r;
    end else if (hold_hit) begin
      cmd.space = SP_HOLD;
      first     = hold_first_r;
      last      = hold_last_r;
    end else begin
      cmd.space = SP_INREG;
      first     = inreg_first_r;
      last      = inreg_last_r;
    end

    if (bad_func) begin
      cmd.status = ST_BAD_FUNC;
    end else if (!in_item.local_side && !need_ok) begin
      cmd.status = ST_BAD_ADDR;
    end else if (!(coil_hit || disc_hit || hold_hit || inreg_hit)) begin
      cmd.status = ST_BAD_ADDR;
    end else begin
      cmd.status = ST_OK;
    end

    cmd.wr    = wr;
    cmd.off   = in_item.start_address - first;
    cmd.span  = last - first;
    cmd.cnt   = (in_item.element_count > MAX_BITS) ? MAX_BITS : in_item.element_count;
    cmd.whole = in_item.reg_width;
    cmd.wd    = in_item.write_data;
  end

endmodule

FILE: hw/rtl/mbsdm_cmdq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsdm_cmdq
// Short queue of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module mbsdm_cmdq
  import mbsdm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  q_ctl_t ctl,
  output q_sts_t sts,
  input  cmd_t   wdata,
  output cmd_t   rdata
);

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr_r, wptr_nxt;
  logic [CMDQ_AW-1:0] rptr_r, rptr_nxt;
  logic [CMDQ_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign sts.full  = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign sts.empty = (cnt_r == '0);
  assign rdata     = mem_r[rptr_r];

  always_comb begin
    do_push  = ctl.push && !sts.full;
    do_pop   = ctl.pop && !sts.empty;
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (CMDQ_AW+1)'(do_push) - (CMDQ_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/mbsdm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsdm_back
// Carries out classified requests against the four stores and holds the
// result register. Bit stores are kept as 16-bit rows; a bit access reads
// two neighboring rows; a write merges and writes them back one per cycle.
// ----------------------------------------------------------------------------
module mbsdm_back
  import mbsdm_pkg::*;
#(
  parameter int COIL_DEPTH     = 64,
  parameter int DISCRETE_DEPTH = 64,
  parameter int HOLDING_DEPTH  = 64,
  parameter int INREG_DEPTH    = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_sts_t    q_sts,
  input  cmd_t      head,
  output logic      q_pop,
  output logic      clearing,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  localparam int COIL_ROWS = (COIL_DEPTH + ROW_BITS - 1) / ROW_BITS;
  localparam int DISC_ROWS = (DISCRETE_DEPTH + ROW_BITS - 1) / ROW_BITS;
  localparam int CROW_W    = (COIL_ROWS > 1) ? $clog2(COIL_ROWS) : 1;
  localparam int DROW_W    = (DISC_ROWS > 1) ? $clog2(DISC_ROWS) : 1;
  localparam int HREG_W    = (HOLDING_DEPTH > 1) ? $clog2(HOLDING_DEPTH) : 1;
  localparam int IREG_W    = (INREG_DEPTH > 1) ? $clog2(INREG_DEPTH) : 1;
  localparam int CLR_M1    = (COIL_ROWS > DISC_ROWS) ? COIL_ROWS : DISC_ROWS;
  localparam int CLR_M2    = (HOLDING_DEPTH > INREG_DEPTH) ? HOLDING_DEPTH : INREG_DEPTH;
  localparam int CLR_LEN   = (CLR_M1 > CLR_M2) ? CLR_M1 : CLR_M2;
  localparam int CLR_W     = $clog2(CLR_LEN + 1);

  logic [15:0] coil_mem  [COIL_ROWS];
  logic [15:0] disc_mem  [DISC_ROWS];
  logic [15:0] hold_mem  [HOLDING_DEPTH];
  logic [15:0] inreg_mem [INREG_DEPTH];

  bk_state_t   state_r, state_nxt;
  logic [CLR_W-1:0] clr_r, clr_nxt;
  cmd_t        cur_r;
  logic [4:0]  eff_r, eff_nxt;
  logic        reg_ok_r, reg_ok_nxt;
  logic [15:0] hiw_r, hiw_nxt;
  out_item_t   res_r, res_nxt;
  logic        res_valid_r, res_valid_nxt;

  logic [15:0] coil_qa_r, coil_qb_r, disc_qa_r, disc_qb_r, hold_q_r, inreg_q_r;

  // ---- request setup from the queue head -----------------------------------
  logic [11:0] head_row;
  logic [12:0] head_row1;
  logic [15:0] top_pos, diff;
  logic [16:0] room;

  always_comb begin
    head_row  = head.off[15:4];
    head_row1 = {1'b0, head_row} + 13'd1;

    case (head.space)
      SP_COIL:  top_pos = (head.span < 16'(COIL_DEPTH - 1)) ? head.span
                                                             : 16'(COIL_DEPTH - 1);
      SP_DISC:  top_pos = (head.span < 16'(DISCRETE_DEPTH - 1)) ? head.span
                                                                 : 16'(DISCRETE_DEPTH - 1);
      default:  top_pos = '0;
    endcase
    diff = top_pos - head.off;
    room = {1'b0, diff} + 17'd1;
    if (head.off > top_pos) begin
      eff_nxt = 5'd0;
    end else if (room < 17'(head.cnt)) begin
      eff_nxt = room[4:0];
    end else begin
      eff_nxt = head.cnt;
    end

    case (head.space)
      SP_HOLD:  reg_ok_nxt = head.off < 16'(HOLDING_DEPTH);
      SP_INREG: reg_ok_nxt = head.off < 16'(INREG_DEPTH);
      default:  reg_ok_nxt = 1'b0;
    endcase
  end

  // Reads are issued every cycle at the head's address; only the cycle in
  // which the head is taken matters.
  always_ff @(posedge clk) begin
    coil_qa_r <= coil_mem[head_row[CROW_W-1:0]];
    coil_qb_r <= coil_mem[head_row1[CROW_W-1:0]];
    disc_qa_r <= disc_mem[head_row[DROW_W-1:0]];
    disc_qb_r <= disc_mem[head_row1[DROW_W-1:0]];
    hold_q_r  <= hold_mem[head.off[HREG_W-1:0]];
    inreg_q_r <= inreg_mem[head.off[IREG_W-1:0]];
  end

  // ---- execution datapath ---------------------------------------------------
  logic [11:0] cur_row;
  logic [12:0] cur_row1;
  logic [12:0] rows_sel;
  logic        lo_ok, hi_ok;
  logic [31:0] pair, merged, wmask32;
  logic [15:0] mask16, bit_rd, word, reg_rd, reg_wr;

  always_comb begin
    cur_row  = cur_r.off[15:4];
    cur_row1 = {1'b0, cur_row} + 13'd1;
    rows_sel = (cur_r.space == SP_COIL) ? 13'(COIL_ROWS) : 13'(DISC_ROWS);
    lo_ok    = {1'b0, cur_row} < rows_sel;
    hi_ok    = cur_row1 < rows_sel;

    pair    = (cur_r.space == SP_COIL) ? {coil_qb_r, coil_qa_r} : {disc_qb_r, disc_qa_r};
    mask16  = 16'((32'd1 << eff_r) - 32'd1);
    wmask32 = {16'd0, mask16} << cur_r.off[3:0];
    bit_rd  = 16'(pair >> cur_r.off[3:0]) & mask16;
    merged  = (pair & ~wmask32) | ({16'd0, cur_r.wd & mask16} << cur_r.off[3:0]);

    word   = (cur_r.space == SP_HOLD) ? hold_q_r : inreg_q_r;
    reg_rd = !reg_ok_r ? 16'd0 : (cur_r.whole ? word : {8'd0, word[7:0]});
    reg_wr = cur_r.whole ? cur_r.wd : {word[15:8], cur_r.wd[7:0]};
  end

  // ---- sequencer: next state ------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLEAR: begin
        if (clr_r == CLR_W'(CLR_LEN - 1)) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (q_pop && head.status == ST_OK) state_nxt = B_EXEC;
      end
      B_EXEC: begin
        if (cur_r.wr && (cur_r.space == SP_COIL || cur_r.space == SP_DISC)) begin
          state_nxt = B_WRHI;
        end else begin
          state_nxt = B_IDLE;
        end
      end
      B_WRHI:  state_nxt = B_IDLE;
      default: state_nxt = B_CLEAR;
    endcase
  end

  // ---- sequencer: outputs ---------------------------------------------------
  logic                coil_we, disc_we, hold_we, inreg_we;
  logic [CROW_W-1:0]   coil_wa;
  logic [DROW_W-1:0]   disc_wa;
  logic [HREG_W-1:0]   hold_wa;
  logic [IREG_W-1:0]   inreg_wa;
  logic [15:0]         coil_wd, disc_wd, hold_wd, inreg_wd;

  always_comb begin
    q_pop         = 1'b0;
    clearing      = 1'b0;
    clr_nxt       = clr_r;
    hiw_nxt       = hiw_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !pop;
    coil_we  = 1'b0;  coil_wa  = cur_row[CROW_W-1:0];  coil_wd  = merged[15:0];
    disc_we  = 1'b0;  disc_wa  = cur_row[DROW_W-1:0];  disc_wd  = merged[15:0];
    hold_we  = 1'b0;  hold_wa  = cur_r.off[HREG_W-1:0]; hold_wd  = reg_wr;
    inreg_we = 1'b0;  inreg_wa = cur_r.off[IREG_W-1:0]; inreg_wd = reg_wr;

    case (state_r)
      B_CLEAR: begin
        clearing = 1'b1;
        clr_nxt  = clr_r + 1'b1;
        coil_we  = clr_r < CLR_W'(COIL_ROWS);
        disc_we  = clr_r < CLR_W'(DISC_ROWS);
        hold_we  = clr_r < CLR_W'(HOLDING_DEPTH);
        inreg_we = clr_r < CLR_W'(INREG_DEPTH);
        coil_wa  = clr_r[CROW_W-1:0];
        disc_wa  = clr_r[DROW_W-1:0];
        hold_wa  = clr_r[HREG_W-1:0];
        inreg_wa = clr_r[IREG_W-1:0];
        coil_wd  = '0;
        disc_wd  = '0;
        hold_wd  = '0;
        inreg_wd = '0;
      end
      B_IDLE: begin
        q_pop = !q_sts.empty && (!res_valid_r || pop);
        if (q_pop && head.status != ST_OK) begin
          // Rejected request: answered at once, stores untouched.
          res_nxt.status    = head.status;
          res_nxt.read_data = '0;
          res_valid_nxt     = 1'b1;
        end
      end
      B_EXEC: begin
        res_nxt.status = ST_OK;
        res_valid_nxt  = 1'b1;
        hiw_nxt        = merged[31:16];
        case (cur_r.space)
          SP_COIL: begin
            res_nxt.read_data = cur_r.wr ? 16'd0 : bit_rd;
            coil_we           = cur_r.wr && lo_ok;
          end
          SP_DISC: begin
            res_nxt.read_data = cur_r.wr ? 16'd0 : bit_rd;
            disc_we           = cur_r.wr && lo_ok;
          end
          SP_HOLD: begin
            res_nxt.read_data = cur_r.wr ? 16'd0 : reg_rd;
            hold_we           = cur_r.wr && reg_ok_r;
          end
          default: begin
            res_nxt.read_data = cur_r.wr ? 16'd0 : reg_rd;
            inreg_we          = cur_r.wr && reg_ok_r;
          end
        endcase
      end
      B_WRHI: begin
        coil_wa = cur_row1[CROW_W-1:0];
        disc_wa = cur_row1[DROW_W-1:0];
        coil_wd = hiw_r;
        disc_wd = hiw_r;
        coil_we = (cur_r.space == SP_COIL) && hi_ok;
        disc_we = (cur_r.space == SP_DISC) && hi_ok;
      end
      default: ;
    endcase
  end

  // ---- registers ------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    hiw_r <= hiw_nxt;
    if (q_pop) begin
      cur_r    <= head;
      eff_r    <= eff_nxt;
      reg_ok_r <= reg_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (coil_we) coil_mem[coil_wa] <= coil_wd;
  end

  always_ff @(posedge clk) begin
    if (disc_we) disc_mem[disc_wa] <= disc_wd;
  end

  always_ff @(posedge clk) begin
    if (hold_we) hold_mem[hold_wa] <= hold_wd;
  end

  always_ff @(posedge clk) begin
    if (inreg_we) inreg_mem[inreg_wa] <= inreg_wd;
  end

  assign empty    = !res_valid_r;
  assign out_item = res_r;

  // ---- assertions -----------------------------------------------------------
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_CLEAR |-> !q_pop)
    else $error("request taken during store clearing");

  a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_EXEC |-> !res_valid_r)
    else $error("result register busy at execution");

  a_wrhi_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_WRHI |-> $past(state_r) == B_EXEC)
    else $error("second row write without execution step");

  a_reject_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && head.status != ST_OK |=>
      res_valid_r && res_r.status == $past(head.status) && res_r.read_data == 16'd0)
    else $error("rejected request not answered with its exception");

endmodule

FILE: hw/rtl/modbus_slave_data_model.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_slave_data_model
// Modbus slave data store: coils, discrete inputs, holding and input
// registers mapped onto configurable address windows.
//
//   Channel   Ports                          Transfer when
//   input     push, full, in_item            push && !full
//   result    empty, pop, out_item           pop && !empty
//   config    valid, ready, cfg_index/data   valid && ready (ready is always 1)
//
// A rejected request (exception) is answered from the idle state of the back
// part; a read or a register write passes through the execution state, a bit
// write also through a second row-write state (two store rows written back
// through the single write port of each store).
// After reset the stores are cleared one row per cycle; full stays high meanwhile.
// A two-entry request queue lets the front keep taking requests while the
// back waits on a result that has not been popped.
// ----------------------------------------------------------------------------
module modbus_slave_data_model
  import mbsdm_pkg::*;
#(
  parameter int COIL_DEPTH     = 64,
  parameter int DISCRETE_DEPTH = 64,
  parameter int HOLDING_DEPTH  = 64,
  parameter int INREG_DEPTH    = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item,
  input  logic        valid,
  output logic        ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t   front_cmd;
  cmd_t   head;
  q_ctl_t q_ctl;
  q_sts_t q_sts;
  logic   q_pop;
  logic   clearing;

  assign full       = q_sts.full || clearing;
  assign q_ctl.push = push && !full;
  assign q_ctl.pop  = q_pop;

  mbsdm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (valid),
    .ready     (ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (front_cmd)
  );

  mbsdm_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (q_ctl),
    .sts   (q_sts),
    .wdata (front_cmd),
    .rdata (head)
  );

  mbsdm_back #(
    .COIL_DEPTH     (COIL_DEPTH),
    .DISCRETE_DEPTH (DISCRETE_DEPTH),
    .HOLDING_DEPTH  (HOLDING_DEPTH),
    .INREG_DEPTH    (INREG_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_sts    (q_sts),
    .head     (head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
